### sv/mttw_pkg.sv
package mttw_pkg;

  localparam int DEF_COLS  = 80;
  localparam int DEF_ROWS  = 25;
  localparam int DEF_TERMS = 3;

  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] DEF_COLOR    = 8'd10;
  localparam logic [0:0] REG_DEFAULT_COLOR = 1'b0;

  typedef enum logic [2:0] {
    OP_PUT    = 3'd0,
    OP_SETCUR = 3'd1,
    OP_COLOR  = 3'd2,
    OP_RESET  = 3'd3,
    OP_SELECT = 3'd4,
    OP_NEXT   = 3'd5,
    OP_PREV   = 3'd6,
    OP_READ   = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_BLANK,
    ST_DONE
  } state_t;

endpackage

### sv/multi_text_terminal_writer_core.sv
// multi-terminal text writer with per-terminal cursor, color and cell buffer
//
// configuration: apb-style port, one register (default_color at address 0),
// written only while idle: a rule for the user that the block does not enforce.
// pready is always high. commands: an item is taken with start high while
// busy is low. busy stays high until the cycle of the result strobe. each
// result is on the result ports for one cycle, marked by done; the receiver
// cannot stall it. a command without a scroll or a clear goes through ST_DONE
// (read cell: ST_READ, the memory read is issued at the transfer) to the
// result strobe; a new command is not taken before that strobe's cycle.
// a scroll copies ROWS-1 lines (per cell one memory read in ST_SCR_RD and one
// write in ST_SCR_WR) and blanks the bottom line.
// a terminal reset clears ROWS*COLS cells, one per cycle.
// after reset a clearing pass over TERMS*ROWS*COLS cells fills every buffer
// with spaces in the default color; start is not taken meanwhile (busy high).
// the cell memory is one single-port-write, one-port-read ram; the cell
// index is term*ROWS*COLS + row*COLS + col.
module multi_text_terminal_writer_core
  import mttw_pkg::*;
#(
  parameter int COLS  = DEF_COLS,
  parameter int ROWS  = DEF_ROWS,
  parameter int TERMS = DEF_TERMS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [1:0]  term,
  input  logic [7:0]  char_code,
  input  logic [6:0]  col_x,
  input  logic [4:0]  row_y,
  input  logic [7:0]  color,
  output logic        done,
  output logic [10:0] cursor_index,
  output logic        cursor_update,
  output logic [1:0]  current_term,
  output logic [15:0] cell_value,
  output logic        bad_index
);

  localparam int TSIZE = ROWS * COLS;
  localparam int DEPTH = TERMS * TSIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TW    = (TERMS > 1) ? $clog2(TERMS) : 1;

  state_t state, state_next;

  logic [7:0]    default_color;
  logic [RW-1:0] cur_row [TERMS];
  logic [CW-1:0] cur_col [TERMS];
  logic [7:0]    attr [TERMS];
  logic [1:0]    shown;

  logic [TW-1:0] t_sel;
  logic [AW-1:0] base;
  logic [AW-1:0] ptr, ptr_next;
  logic [AW-1:0] ptr_end, ptr_end_next;
  logic [AW-1:0] blank_end, blank_end_next;
  logic [7:0]    fill_color, fill_color_next;
  logic [15:0]   cell_value_next;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;

  logic [10:0]   cursor_index_next;
  logic          cursor_update_next, bad_index_next, done_next;
  logic [1:0]    shown_next;
  logic [RW-1:0] row_next_v;
  logic [CW-1:0] col_next_v;
  logic [7:0]    attr_next_v;
  logic          term_wr;
  logic [TW-1:0] rsp_t, rsp_t_next;
  logic          rsp_bad, rsp_bad_next;
  logic          rsp_tbad, rsp_tbad_next;
  logic          term_ok, accept, wrap_row;

  mttw_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign pready = 1'b1;
  assign prdata = {24'd0, default_color};
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign term_ok = (32'(term) < TERMS);
  assign t_sel = TW'(term);

  always_ff @(posedge clk) begin
    if (rst) begin
      default_color <= DEF_COLOR;
    end else if (psel && penable && pwrite && paddr == REG_DEFAULT_COLOR) begin
      default_color <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      shown <= 2'd0;
      done  <= 1'b0;
      ptr   <= '0;
      ptr_end <= AW'(DEPTH - 1);
      for (int i = 0; i < TERMS; i++) begin
        cur_row[i] <= '0;
        cur_col[i] <= '0;
        attr[i]    <= DEF_COLOR;
      end
    end else begin
      state <= state_next;
      shown <= shown_next;
      done  <= done_next;
      ptr   <= ptr_next;
      ptr_end <= ptr_end_next;
      if (term_wr) begin
        cur_row[rsp_t_next] <= row_next_v;
        cur_col[rsp_t_next] <= col_next_v;
        attr[rsp_t_next]    <= attr_next_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    blank_end  <= blank_end_next;
    fill_color <= fill_color_next;
    rsp_t      <= rsp_t_next;
    rsp_bad    <= rsp_bad_next;
    rsp_tbad   <= rsp_tbad_next;
    cell_value <= cell_value_next;
    cursor_index  <= cursor_index_next;
    cursor_update <= cursor_update_next;
    bad_index     <= bad_index_next;
  end

  assign current_term = shown;
  assign base = AW'(32'(t_sel) * TSIZE);
  assign wrap_row = (32'(cur_row[t_sel]) + 1 >= ROWS);

  always_comb begin
    state_next      = state;
    shown_next      = shown;
    done_next       = 1'b0;
    ptr_next        = ptr;
    ptr_end_next    = ptr_end;
    blank_end_next  = blank_end;
    fill_color_next = fill_color;
    rsp_t_next      = rsp_t;
    rsp_bad_next    = rsp_bad;
    rsp_tbad_next   = rsp_tbad;
    cell_value_next = 16'd0;
    we    = 1'b0;
    waddr = ptr;
    wdata = {fill_color, SPACE_CODE};
    raddr = ptr;
    term_wr = 1'b0;
    row_next_v  = cur_row[t_sel];
    col_next_v  = cur_col[t_sel];
    attr_next_v = attr[t_sel];
    cursor_index_next  = 11'(32'(cur_row[rsp_t]) * COLS + 32'(cur_col[rsp_t]));
    cursor_update_next = (2'(rsp_t) == shown) && !rsp_tbad;
    bad_index_next     = rsp_bad;
    if (rsp_tbad) begin
      cursor_index_next = 11'd0;
    end
    unique case (state)
      ST_INIT: begin
        we = 1'b1;
        wdata = {default_color, SPACE_CODE};
        ptr_next = ptr + 1'b1;
        if (ptr == ptr_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          rsp_t_next   = t_sel;
          rsp_bad_next = !term_ok;
          rsp_tbad_next = !term_ok;
          state_next   = ST_DONE;
          if (opcode == OP_NEXT) begin
            if (32'(shown) + 1 < TERMS) shown_next = shown + 2'd1;
            rsp_t_next = TW'(shown_next);
            rsp_bad_next = 1'b0;
            rsp_tbad_next = 1'b0;
          end else if (opcode == OP_PREV) begin
            if (shown != 2'd0) shown_next = shown - 2'd1;
            rsp_t_next = TW'(shown_next);
            rsp_bad_next = 1'b0;
            rsp_tbad_next = 1'b0;
          end else if (term_ok) begin
            unique case (opcode_t'(opcode))
              OP_PUT: begin
                term_wr = 1'b1;
                fill_color_next = attr[t_sel];
                if (char_code != NEWLINE_CODE) begin
                  we = 1'b1;
                  waddr = AW'(32'(base) + 32'(cur_row[t_sel]) * COLS
                              + 32'(cur_col[t_sel]));
                  wdata = {attr[t_sel], char_code};
                end
                if (char_code == NEWLINE_CODE
                    || 32'(cur_col[t_sel]) + 1 >= COLS) begin
                  col_next_v = '0;
                  if (wrap_row) begin
                    row_next_v = RW'(ROWS - 1);
                    ptr_next = base;
                    ptr_end_next = AW'(32'(base) + (ROWS - 1) * COLS - 1);
                    blank_end_next = AW'(32'(base) + TSIZE - 1);
                    state_next = (ROWS > 1) ? ST_SCR_RD : ST_BLANK;
                  end else begin
                    row_next_v = cur_row[t_sel] + 1'b1;
                  end
                end else begin
                  col_next_v = cur_col[t_sel] + 1'b1;
                end
              end
              OP_SETCUR: begin
                term_wr = 1'b1;
                if (32'(col_x) < COLS) col_next_v = CW'(col_x);
                if (32'(row_y) < ROWS) row_next_v = RW'(row_y);
              end
              OP_COLOR: begin
                term_wr = 1'b1;
                attr_next_v = color;
              end
              OP_RESET: begin
                term_wr = 1'b1;
                row_next_v = '0;
                col_next_v = '0;
                attr_next_v = default_color;
                fill_color_next = default_color;
                ptr_next = base;
                blank_end_next = AW'(32'(base) + TSIZE - 1);
                state_next = ST_BLANK;
              end
              OP_SELECT: begin
                shown_next = term;
              end
              OP_READ: begin
                if (32'(col_x) < COLS && 32'(row_y) < ROWS) begin
                  raddr = AW'(32'(base) + 32'(row_y) * COLS + 32'(col_x));
                  state_next = ST_READ;
                end else begin
                  rsp_bad_next = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_READ: begin
        cell_value_next = rdata;
        done_next = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCR_RD: begin
        raddr = AW'(32'(ptr) + COLS);
        state_next = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        we = 1'b1;
        wdata = rdata;
        ptr_next = ptr + 1'b1;
        state_next = (ptr == ptr_end) ? ST_BLANK : ST_SCR_RD;
      end
      ST_BLANK: begin
        we = 1'b1;
        ptr_next = ptr + 1'b1;
        if (ptr == blank_end) state_next = ST_DONE;
      end
      ST_DONE: begin
        done_next = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### sv/mttw_ram.sv
module mttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sim/mttw_checker.sv
module mttw_checker
  import mttw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  opcode,
  input  logic [1:0]  term,
  input  logic [7:0]  char_code,
  input  logic [6:0]  col_x,
  input  logic [4:0]  row_y,
  input  logic [7:0]  color,
  input  logic        done,
  input  logic [10:0] cursor_index,
  input  logic        cursor_update,
  input  logic [1:0]  current_term,
  input  logic [15:0] cell_value,
  input  logic        bad_index,
  output int          errors,
  output int          pending
);

  localparam int NCOLS  = DEF_COLS;
  localparam int NROWS  = DEF_ROWS;
  localparam int NTERMS = DEF_TERMS;

  typedef struct packed {
    logic [10:0] cursor_index;
    logic        cursor_update;
    logic [1:0]  current_term;
    logic [15:0] cell_value;
    logic        bad_index;
  } term_result_t;

  term_result_t result_q[$];

  logic [7:0]  dflt_color;
  logic [4:0]  crow [NTERMS];
  logic [6:0]  ccol [NTERMS];
  logic [7:0]  tcolor [NTERMS];
  logic [15:0] screen [NTERMS][NROWS][NCOLS];
  logic [1:0]  shown;

  assign pending = result_q.size();

  task automatic blank_row(int t, int r);
    for (int x = 0; x < NCOLS; x++) screen[t][r][x] = {tcolor[t], SPACE_CODE};
  endtask

  task automatic clear_screen(int t);
    crow[t] = '0;
    ccol[t] = '0;
    tcolor[t] = dflt_color;
    for (int r = 0; r < NROWS; r++) blank_row(t, r);
  endtask

  task automatic line_feed(int t);
    if (crow[t] + 1 >= NROWS) begin
      crow[t] = 5'(NROWS - 1);
      for (int r = 0; r + 1 < NROWS; r++)
        for (int x = 0; x < NCOLS; x++) screen[t][r][x] = screen[t][r + 1][x];
      blank_row(t, NROWS - 1);
    end else begin
      crow[t] = crow[t] + 1'b1;
    end
  endtask

  task automatic predict_command(output term_result_t res);
    int t;
    logic bad;
    logic [15:0] cell_word;
    int idx;
    t = term;
    bad = 1'b0;
    cell_word = '0;
    if (opcode_t'(opcode) == OP_NEXT) begin
      if (shown + 1 < NTERMS) shown = shown + 2'd1;
      t = shown;
    end else if (opcode_t'(opcode) == OP_PREV) begin
      if (shown > 0) shown = shown - 2'd1;
      t = shown;
    end else if (term >= NTERMS) begin
      bad = 1'b1;
    end else begin
      case (opcode_t'(opcode))
        OP_PUT: begin
          if (char_code == NEWLINE_CODE) begin
            line_feed(t);
            ccol[t] = '0;
          end else begin
            screen[t][crow[t]][ccol[t]] = {tcolor[t], char_code};
            if (ccol[t] + 1 >= NCOLS) begin
              ccol[t] = '0;
              line_feed(t);
            end else begin
              ccol[t] = ccol[t] + 1'b1;
            end
          end
        end
        OP_SETCUR: begin
          if (col_x < NCOLS) ccol[t] = col_x;
          if (row_y < NROWS) crow[t] = row_y;
        end
        OP_COLOR: tcolor[t] = color;
        OP_RESET: clear_screen(t);
        OP_SELECT: shown = 2'(t);
        default: begin
          if (col_x < NCOLS && row_y < NROWS) cell_word = screen[t][row_y][col_x];
          else bad = 1'b1;
        end
      endcase
    end
    if (bad && term >= NTERMS) begin
      res.cursor_index = '0;
      res.cursor_update = 1'b0;
    end else begin
      idx = crow[t] * NCOLS + ccol[t];
      res.cursor_index = idx[10:0];
      res.cursor_update = (t == shown);
    end
    res.current_term = shown;
    res.cell_value = cell_word;
    res.bad_index = bad;
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    term_result_t exp_r;
    term_result_t got;
    if (rst) begin
      dflt_color = DEF_COLOR;
      shown = '0;
      for (int t = 0; t < NTERMS; t++) clear_screen(t);
      result_q.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (result_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $time);
          errors++;
        end else begin
          exp_r = result_q.pop_front();
          check_field("cursor_index", exp_r.cursor_index, cursor_index);
          check_field("cursor_update", exp_r.cursor_update, cursor_update);
          check_field("current_term", exp_r.current_term, current_term);
          check_field("cell_value", exp_r.cell_value, cell_value);
          check_field("bad_index", exp_r.bad_index, bad_index);
        end
      end
      if (start && !busy) begin
        predict_command(got);
        result_q.push_back(got);
      end
      if (psel && penable && pwrite && pready && paddr == REG_DEFAULT_COLOR)
        dflt_color = pwdata[7:0];
    end
  end

endmodule

### sim/testbench.sv
module testbench;
  import mttw_pkg::*;

  localparam longint CYCLE_LIMIT = 20000000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic        paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [2:0]  opcode;
  logic [1:0]  term;
  logic [7:0]  char_code;
  logic [6:0]  col_x;
  logic [4:0]  row_y;
  logic [7:0]  color;
  logic        done;
  logic [10:0] cursor_index;
  logic        cursor_update;
  logic [1:0]  current_term;
  logic [15:0] cell_value;
  logic        bad_index;
  int          errors;
  int          pending;
  longint      cycles;

  multi_text_terminal_writer_core u_top (.*);

  mttw_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_default_color(logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_DEFAULT_COLOR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(opcode_t op, logic [1:0] t, logic [7:0] ch, logic [6:0] x,
                      logic [4:0] y, logic [7:0] c, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    term <= t;
    char_code <= ch;
    col_x <= x;
    row_y <= y;
    color <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random(bit quiet);
    int p;
    opcode_t op;
    logic [7:0] ch;
    logic [6:0] x;
    logic [4:0] y;
    logic [1:0] t;
    int gap;
    p = $urandom_range(0, 99);
    if (p < 45) op = OP_PUT;
    else if (p < 57) op = OP_SETCUR;
    else if (p < 65) op = OP_COLOR;
    else if (p < 68) op = OP_RESET;
    else if (p < 76) op = OP_SELECT;
    else if (p < 82) op = OP_NEXT;
    else if (p < 88) op = OP_PREV;
    else op = OP_READ;
    t = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    ch = ($urandom_range(0, 11) == 0) ? NEWLINE_CODE : 8'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      x = 7'($urandom);
      y = 5'($urandom);
    end else begin
      x = 7'($urandom_range(0, DEF_COLS - 1));
      y = 5'($urandom_range(0, DEF_ROWS - 1));
    end
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    send(op, t, ch, x, y, 8'($urandom), gap);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 1'b0;
    pwdata = '0;
    start = 1'b0;
    opcode = OP_PUT;
    term = '0;
    char_code = '0;
    col_x = '0;
    row_y = '0;
    color = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // directed
    send(OP_READ, 2'd0, 8'd0, 7'd0, 5'd0, 8'd0, 0);
    send(OP_PUT, 2'd0, 8'd0, 7'd0, 5'd0, 8'd0, 0);
    send(OP_PUT, 2'd0, 8'hff, 7'd0, 5'd0, 8'd0, 1);
    send(OP_PUT, 2'd0, NEWLINE_CODE, 7'd0, 5'd0, 8'd0, 0);
    send(OP_COLOR, 2'd0, 8'd0, 7'd0, 5'd0, 8'hff, 0);
    send(OP_SETCUR, 2'd0, 8'd0, 7'd79, 5'd24, 8'd0, 0);
    send(OP_PUT, 2'd0, 8'h41, 7'd0, 5'd0, 8'd0, 0);
    send(OP_PUT, 2'd0, NEWLINE_CODE, 7'd0, 5'd0, 8'd0, 0);
    send(OP_READ, 2'd0, 8'd0, 7'd79, 5'd23, 8'd0, 0);
    send(OP_READ, 2'd0, 8'd0, 7'd0, 5'd0, 8'd0, 0);
    send(OP_SETCUR, 2'd1, 8'd0, 7'd127, 5'd31, 8'd0, 0);
    send(OP_SETCUR, 2'd1, 8'd0, 7'd5, 5'd31, 8'd0, 0);
    send(OP_SETCUR, 2'd1, 8'd0, 7'd80, 5'd3, 8'd0, 0);
    send(OP_READ, 2'd1, 8'd0, 7'd80, 5'd0, 8'd0, 0);
    send(OP_READ, 2'd1, 8'd0, 7'd0, 5'd25, 8'd0, 0);
    send(OP_PUT, 2'd3, 8'h42, 7'd0, 5'd0, 8'd0, 0);
    send(OP_READ, 2'd3, 8'd0, 7'd0, 5'd0, 8'd0, 0);
    send(OP_SELECT, 2'd3, 8'd0, 7'd0, 5'd0, 8'd0, 0);
    send(OP_SELECT, 2'd2, 8'd0, 7'd0, 5'd0, 8'd0, 0);
    send(OP_NEXT, 2'd0, 8'd0, 7'd0, 5'd0, 8'd0, 0);
    send(OP_PREV, 2'd3, 8'd0, 7'd0, 5'd0, 8'd0, 0);
    send(OP_PREV, 2'd0, 8'd0, 7'd0, 5'd0, 8'd0, 0);
    send(OP_PREV, 2'd0, 8'd0, 7'd0, 5'd0, 8'd0, 0);
    send(OP_NEXT, 2'd0, 8'd0, 7'd0, 5'd0, 8'd0, 0);
    send(OP_RESET, 2'd0, 8'd0, 7'd0, 5'd0, 8'd0, 0);

    for (int phase = 0; phase < 5; phase++) begin
      start <= 1'b0;
      wait_idle();
      case (phase)
        0: write_default_color(32'h0000_0000);
        1: write_default_color(32'hffff_ffff);
        2: write_default_color($urandom);
        3: write_default_color($urandom);
        default: write_default_color(32'(DEF_COLOR));
      endcase
      send(OP_RESET, 2'($urandom_range(0, 2)), 8'd0, 7'd0, 5'd0, 8'd0, 0);
      for (int i = 0; i < 125; i++) begin
        if (phase == 2 && i == 60) begin
          start <= 1'b0;
          wait_idle();
        end
        send_random(phase == 4);
      end
    end
    start <= 1'b0;

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
sv/mttw_pkg.sv
sv/mttw_ram.sv
sv/multi_text_terminal_writer_core.sv
sim/mttw_checker.sv
sim/testbench.sv
